@@ sv/raw_scanline_repacker_defines.svh @@
// Assertion macros for the raw scanline repacker.
// Needs clk and rst in the scope where a macro is used.
`ifndef RAW_SCANLINE_REPACKER_DEFINES_SVH
`define RAW_SCANLINE_REPACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rsr_pkg.sv @@
// Shared types and constants for the raw scanline repacker.
// No dependencies; used by the channel interfaces and the top level.
package rsr_pkg;

  localparam int unsigned DEF_MAX_LINE_WIDTH = 16384;

  localparam int SRC_W   = 8;
  localparam int VAL_W   = 16;
  localparam int LW_W    = 15;
  localparam int MODE_W  = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

  // Packing modes
  localparam logic [MODE_W-1:0] MODE_COPY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_P10  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_P12  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_B16  = 2'd3;

  // Group positions
  localparam logic [2:0] LAST_BYTE_P10 = 3'd4;
  localparam logic [2:0] LAST_BYTE_P12 = 3'd2;
  localparam logic [2:0] TAIL_GROUP    = 3'd6;

  // Result queue
  localparam int MAX_RESULTS = 5;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = 3;
  localparam int CNT_W       = 4;

  typedef struct packed {
    logic [VAL_W-1:0] out_value;
    logic             out_line_last;
  } result_t;

endpackage

@@ sv/rsr_src_if.sv @@
// Source byte channel of the raw scanline repacker.
// Depends on rsr_pkg for the field widths.
interface rsr_src_if;
  import rsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] src_byte;
  logic             src_line_end;

  modport source(output valid, output src_byte, output src_line_end, input ready);
  modport sink(input valid, input src_byte, input src_line_end, output ready);
endinterface

@@ sv/rsr_out_if.sv @@
// Output value channel of the raw scanline repacker.
// Depends on rsr_pkg for the field widths.
interface rsr_out_if;
  import rsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] out_value;
  logic             out_line_last;

  modport source(output valid, output out_value, output out_line_last, input ready);
  modport sink(input valid, input out_value, input out_line_last, output ready);
endinterface

@@ sv/raw_scanline_repacker.sv @@
// Raw scanline repacker: copy, packed 10/12-bit regroup, block 10-to-16-bit unpack.
// Results of an accepted byte are registered in the result queue ahead of dst.
// Throughput: one source byte per cycle; results leave one per cycle while dst is
// ready, from an 8-entry result queue, and src stalls only while the queue lacks
// room for the results of the next byte (up to five in packed 10-bit mode).
// Reset: synchronous rst sets copy mode, width 1; clears counters, queue pointers.
`include "raw_scanline_repacker_defines.svh"

module raw_scanline_repacker #(
  parameter int unsigned MAX_LINE_WIDTH = rsr_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  rsr_src_if.sink                          src,
  rsr_out_if.source                        dst
);
  import rsr_pkg::*;

  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CW = (WW > 16) ? WW : 16;
  localparam logic [CW-1:0] MAX_W = CW'(MAX_LINE_WIDTH);

  // Configuration and line state
  logic [MODE_W-1:0] pack_mode;
  logic [LW_W-1:0]   line_width;
  logic [2:0]        byte_in_group;
  logic [2:0]        group_in_block;
  logic [LW_W-1:0]   pixels_emitted;
  logic              line_complete;
  logic [SRC_W-1:0]  group_buffer [MAX_RESULTS];

  // Result queue
  result_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  logic              acc;
  logic              pop;
  logic [2:0]        idx;
  logic [SRC_W-1:0]  b [MAX_RESULTS];
  logic [2:0]        byte_in_group_next;
  logic [2:0]        group_in_block_next;
  logic [2:0]        add_cnt;
  logic [2:0]        nres;
  logic [2:0]        need;
  logic [2:0]        push_n;
  logic [CW-1:0]     eff_width;
  logic [CW-1:0]     sum;
  logic              done;
  logic              done_hit;
  logic [VAL_W-1:0]  m3_val;
  result_t           res [MAX_RESULTS];

  assign acc = src.valid && src.ready;
  assign pop = dst.valid && dst.ready;

  // Width clamp: zero acts as one, saturate at the maximum.
  always_comb begin
    if (line_width == '0) begin
      eff_width = CW'(1);
    end else if (CW'(line_width) > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = CW'(line_width);
    end
  end

  always_comb begin
    idx = (byte_in_group > LAST_BYTE_P10) ? LAST_BYTE_P10 : byte_in_group;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      b[k] = group_buffer[k];
    end
    b[idx] = src.src_byte;

    // Mode 3 pixel picked by position in the group
    if (group_in_block >= TAIL_GROUP) begin
      m3_val = {b[1][1:0], b[0], 6'b0};
    end else begin
      case (idx)
        3'd1:    m3_val = {b[1][1:0], b[0], 6'b0};
        3'd2:    m3_val = {b[2][3:0], b[1][7:2], 6'b0};
        3'd3:    m3_val = {b[3][5:0], b[2][7:4], 6'b0};
        default: m3_val = {b[4], b[3][7:6], 6'b0};
      endcase
    end

    add_cnt             = 3'd0;
    nres                = 3'd0;
    byte_in_group_next  = byte_in_group;
    group_in_block_next = group_in_block;
    case (pack_mode)
      MODE_COPY: begin
        add_cnt            = 3'd1;
        nres               = 3'd1;
        byte_in_group_next = 3'd0;
      end
      MODE_P10: begin
        if (idx >= LAST_BYTE_P10) begin
          add_cnt            = 3'd4;
          nres               = 3'd5;
          byte_in_group_next = 3'd0;
        end else begin
          byte_in_group_next = idx + 3'd1;
        end
      end
      MODE_P12: begin
        if (idx >= LAST_BYTE_P12) begin
          add_cnt            = 3'd2;
          nres               = 3'd3;
          byte_in_group_next = 3'd0;
        end else begin
          byte_in_group_next = idx + 3'd1;
        end
      end
      MODE_B16: begin
        if (idx >= 3'd1) begin
          add_cnt = 3'd1;
          nres    = 3'd1;
        end
        if (group_in_block >= TAIL_GROUP) begin
          if (idx >= 3'd1) begin
            byte_in_group_next  = 3'd0;
            group_in_block_next = 3'd0;
          end else begin
            byte_in_group_next = idx + 3'd1;
          end
        end else if (idx >= LAST_BYTE_P10) begin
          byte_in_group_next  = 3'd0;
          group_in_block_next = group_in_block + 3'd1;
        end else begin
          byte_in_group_next = idx + 3'd1;
        end
      end
      default: begin
        add_cnt = 3'd0;
      end
    endcase

    sum  = CW'(pixels_emitted) + CW'(add_cnt);
    done = (add_cnt != 3'd0) && (sum >= eff_width);

    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
    end
    case (pack_mode)
      MODE_COPY: begin
        res[0] = '{out_value: {8'h00, b[idx]}, out_line_last: done};
      end
      MODE_P10: begin
        res[0] = '{out_value: {8'h00, b[0]}, out_line_last: 1'b0};
        res[1] = '{out_value: {8'h00, b[4][1:0], b[1][7:2]}, out_line_last: 1'b0};
        res[2] = '{out_value: {8'h00, b[1][1:0], b[4][3:2], b[2][7:4]},
                   out_line_last: 1'b0};
        res[3] = '{out_value: {8'h00, b[2][3:0], b[4][5:4], b[3][7:6]},
                   out_line_last: 1'b0};
        res[4] = '{out_value: {8'h00, b[3][5:0], b[4][7:6]}, out_line_last: done};
      end
      MODE_P12: begin
        res[0] = '{out_value: {8'h00, b[0]}, out_line_last: 1'b0};
        res[1] = '{out_value: {8'h00, b[2][3:0], b[1][7:4]}, out_line_last: 1'b0};
        res[2] = '{out_value: {8'h00, b[1][3:0], b[2][7:4]}, out_line_last: done};
      end
      MODE_B16: begin
        res[0] = '{out_value: m3_val, out_line_last: done};
      end
      default: begin
        res[0] = '0;
      end
    endcase
  end

  // Room check uses state only, never the incoming payload.
  assign need     = line_complete ? 3'd0 : nres;
  assign push_n   = acc ? need : 3'd0;
  assign done_hit = acc && !line_complete && done;
  assign src.ready = ({1'b0, count} + {2'b00, need}) <= (CNT_W + 1)'(FIFO_DEPTH);

  assign dst.valid         = (count != '0);
  assign dst.out_value     = fifo[rd_ptr].out_value;
  assign dst.out_line_last = fifo[rd_ptr].out_line_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_mode      <= MODE_COPY;
      line_width     <= LW_W'(1);
      byte_in_group  <= 3'd0;
      group_in_block <= 3'd0;
      pixels_emitted <= '0;
      line_complete  <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PACK_MODE:  pack_mode  <= cfg_data[MODE_W-1:0];
          CFG_LINE_WIDTH: line_width <= cfg_data[LW_W-1:0];
          default:        pack_mode  <= pack_mode;
        endcase
      end
      if (acc) begin
        // Line end clears the line state after the byte is processed.
        if (src.src_line_end) begin
          byte_in_group  <= 3'd0;
          group_in_block <= 3'd0;
          pixels_emitted <= '0;
          line_complete  <= 1'b0;
        end else if (!line_complete) begin
          byte_in_group  <= byte_in_group_next;
          group_in_block <= group_in_block_next;
          if (add_cnt != 3'd0) begin
            pixels_emitted <= sum[LW_W-1:0];
          end
          if (done) begin
            line_complete <= 1'b1;
          end
        end
      end
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (acc && !line_complete) begin
      group_buffer[idx] <= src.src_byte;
    end
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (3'(k) < push_n) begin
        fifo[wr_ptr + PTR_W'(k)] <= res[k];
      end
    end
  end

  `RSR_ASSERT_NOW(a_queue_bound, 1'b1, count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `RSR_ASSERT_NEXT(a_no_push_done, acc && line_complete, count <= $past(count), "push after line complete")
  `RSR_ASSERT_NEXT(a_line_end_clear, acc && src.src_line_end, byte_in_group == 3'd0 && group_in_block == 3'd0 && pixels_emitted == '0 && !line_complete, "line end did not clear counters")
  `RSR_ASSERT_NEXT(a_last_sets_done, done_hit && !src.src_line_end, line_complete, "line last without line complete")
  `RSR_ASSERT_NOW(a_group_range, 1'b1, group_in_block <= TAIL_GROUP, "group index past block tail")

endmodule
